// ----- rtl/ibl_pkg.sv -----
// ibl_pkg: shared constants, status codes and controller/datapath types
// for the inode byte locator. No dependencies.
`default_nettype none

package ibl_pkg;

   localparam int unsigned MAX_GROUPS       = 256;
   localparam int unsigned MIN_INODE_SIZE   = 128;
   localparam int unsigned FIXED_INODE_SIZE = 128;
   localparam int unsigned MAX_SIZE_LOG     = 6;
   localparam int unsigned BASE_BLOCK_LOG   = 10;   // 1024-byte base block
   localparam int unsigned DIV_STEPS        = 32;
   localparam int unsigned GROUP_W          = $clog2(MAX_GROUPS);
   localparam int unsigned OFFSET_W         = 49;
   localparam int unsigned CSR_INDEX_W      = 3;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOCATE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_GEOMETRY       = 3'd1,
      ST_INO_ZERO       = 3'd2,
      ST_PAST_COUNT     = 3'd3,
      ST_ZERO_PER_GROUP = 3'd4,
      ST_GROUP_RANGE    = 3'd5
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INODES_TOTAL      = 3'd0,
      CSR_INODES_PER_GROUP  = 3'd1,
      CSR_BLOCKS_TOTAL      = 3'd2,
      CSR_BLOCKS_PER_GROUP  = 3'd3,
      CSR_BLOCK_SIZE_LOG    = 3'd4,
      CSR_DYNAMIC_REVISION  = 3'd5,
      CSR_STORED_INODE_SIZE = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      OUT_ZERO,
      OUT_RANGE,
      OUT_FULL
   } out_kind_type;

   typedef enum logic {
      MUL_GROUP,
      MUL_LOCAL
   } mul_sel_type;

   typedef struct packed {
      logic         capture;
      logic         table_write;
      logic         div_start;
      logic         mul_en;
      mul_sel_type  mul_sel;
      logic         load_out;
      out_kind_type out_kind;
      status_type   out_status;
   } dp_cmd_type;

   typedef struct packed {
      status_type early_status;
      logic       div_busy;
      logic       group_bad;
      logic       out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- rtl/ibl_div.sv -----
// ibl_div: 32-bit restoring divider, one quotient bit per cycle.
// Depends on ibl_pkg.
`default_nettype none

module ibl_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             busy,
   output logic [31:0]      quotient,
   output logic [31:0]      remainder
);
   import ibl_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      quot_ff, quot_in;
   logic [31:0]      rem_ff, rem_in;
   logic [32:0]      shifted;
   logic [32:0]      diff;

   always_comb begin
      shifted  = {rem_ff, quot_ff[31]};
      diff     = shifted - {1'b0, divisor};
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (start) begin
         count_in = CNT_W'(DIV_STEPS);
         quot_in  = dividend;
         rem_in   = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         // keep the trial difference when there is no borrow
         if (!diff[32]) begin
            rem_in  = diff[31:0];
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = shifted[31:0];
            quot_in = {quot_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign busy      = (count_ff != '0);
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/ibl_datapath.sv -----
// ibl_datapath: configuration registers, group table memory, divider,
// shared multiplier and result register. Depends on ibl_pkg and ibl_div.
`default_nettype none

module ibl_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_en,
   input  wire logic [2:0]          csr_index,
   input  wire logic [31:0]         csr_write_data,
   input  wire logic [7:0]          req_group_slot,
   input  wire logic [31:0]         req_table_start_block,
   input  wire logic [31:0]         req_inode_number,
   input  wire ibl_pkg::dp_cmd_type cmd,
   output ibl_pkg::dp_stat_type     stat,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [2:0]               rsp_status,
   output logic [48:0]              rsp_byte_offset,
   output logic [31:0]              rsp_group_number,
   output logic [31:0]              rsp_local_index
);
   import ibl_pkg::*;

   // configuration
   logic [31:0] inodes_total_ff;
   logic [31:0] inodes_per_group_ff;
   logic [31:0] blocks_total_ff;
   logic [31:0] grp_blocks_ff;
   logic [3:0]  block_size_log_ff;
   logic        dynamic_revision_ff;
   logic [15:0] stored_isize_ff;

   // working registers
   logic [31:0]         ino_ff;
   logic [63:0]         prod_ff;
   logic [31:0]         table_rd_ff;
   logic [31:0]         table_mem [MAX_GROUPS];

   // result register
   logic                out_valid_ff;
   logic [2:0]          out_status_ff;
   logic [OFFSET_W-1:0] out_offset_ff;
   logic [31:0]         out_group_ff;
   logic [31:0]         out_local_ff;

   logic [15:0]         isize;
   status_type          early_status;
   logic [31:0]         quotient;
   logic [31:0]         remainder;
   logic                div_busy;
   logic [31:0]         mul_a;
   logic [31:0]         mul_b;
   logic [4:0]          shift_amt;
   logic [OFFSET_W-1:0] full_offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         inodes_total_ff      <= '0;
         inodes_per_group_ff  <= '0;
         blocks_total_ff      <= '0;
         grp_blocks_ff        <= '0;
         block_size_log_ff    <= '0;
         dynamic_revision_ff  <= 1'b0;
         stored_isize_ff      <= 16'(FIXED_INODE_SIZE);
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_INODES_TOTAL:      inodes_total_ff      <= csr_write_data;
            CSR_INODES_PER_GROUP:  inodes_per_group_ff  <= csr_write_data;
            CSR_BLOCKS_TOTAL:      blocks_total_ff      <= csr_write_data;
            CSR_BLOCKS_PER_GROUP:  grp_blocks_ff        <= csr_write_data;
            CSR_BLOCK_SIZE_LOG:    block_size_log_ff    <= csr_write_data[3:0];
            CSR_DYNAMIC_REVISION:  dynamic_revision_ff  <= csr_write_data[0];
            CSR_STORED_INODE_SIZE: stored_isize_ff      <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   assign isize = dynamic_revision_ff ? stored_isize_ff : 16'(FIXED_INODE_SIZE);

   always_comb begin
      priority if (block_size_log_ff > 4'(MAX_SIZE_LOG) || grp_blocks_ff == '0 ||
                   isize < 16'(MIN_INODE_SIZE)) begin
         early_status = ST_GEOMETRY;
      end else if (ino_ff == '0) begin
         early_status = ST_INO_ZERO;
      end else if (ino_ff > inodes_total_ff) begin
         early_status = ST_PAST_COUNT;
      end else if (inodes_per_group_ff == '0) begin
         early_status = ST_ZERO_PER_GROUP;
      end else begin
         early_status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ino_ff <= req_inode_number;
      end
   end

   // group table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.table_write && {24'd0, req_group_slot} < 32'(MAX_GROUPS)) begin
         table_mem[req_group_slot[GROUP_W-1:0]] <= req_table_start_block;
      end
      table_rd_ff <= table_mem[quotient[GROUP_W-1:0]];
   end

   ibl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (ino_ff - 32'd1),
      .divisor   (inodes_per_group_ff),
      .busy      (div_busy),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // shared multiplier: group * blocks per group, then local * inode size
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_GROUP: begin
            mul_a = quotient;
            mul_b = grp_blocks_ff;
         end
         MUL_LOCAL: begin
            mul_a = remainder;
            mul_b = {16'd0, isize};
         end
         default: begin
            mul_a = quotient;
            mul_b = grp_blocks_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   assign shift_amt   = 5'(BASE_BLOCK_LOG) + {1'b0, block_size_log_ff};
   assign full_offset = ({17'd0, table_rd_ff} << shift_amt) + {1'b0, prod_ff[47:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         out_status_ff <= cmd.out_status;
         unique case (cmd.out_kind)
            OUT_ZERO: begin
               out_offset_ff <= '0;
               out_group_ff  <= '0;
               out_local_ff  <= '0;
            end
            OUT_RANGE: begin
               out_offset_ff <= '0;
               out_group_ff  <= quotient;
               out_local_ff  <= remainder;
            end
            OUT_FULL: begin
               out_offset_ff <= full_offset;
               out_group_ff  <= quotient;
               out_local_ff  <= remainder;
            end
            default: begin
               out_offset_ff <= '0;
               out_group_ff  <= '0;
               out_local_ff  <= '0;
            end
         endcase
      end
   end

   always_comb begin
      stat.early_status = early_status;
      stat.div_busy     = div_busy;
      stat.group_bad    = (prod_ff >= {32'd0, blocks_total_ff}) ||
                          (quotient >= 32'(MAX_GROUPS));
      stat.out_free     = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_byte_offset  = out_offset_ff;
   assign rsp_group_number = out_group_ff;
   assign rsp_local_index  = out_local_ff;

endmodule

`default_nettype wire

// ----- rtl/ibl_ctrl.sv -----
// ibl_ctrl: sequencer for table writes and inode lookups.
// Depends on ibl_pkg; drives the datapath through dp_cmd_type.
`default_nettype none

module ibl_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_cmd,
   input  wire ibl_pkg::dp_stat_type stat,
   output ibl_pkg::dp_cmd_type       cmd
);
   import ibl_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIVIDE,
      S_MUL_GROUP,
      S_RANGE,
      S_MUL_LOCAL,
      S_FINISH
   } state_type;

   state_type    state_ff;
   out_kind_type kind_ff;
   status_type   status_ff;

   always_comb begin
      cmd            = '0;
      cmd.mul_sel    = MUL_GROUP;
      cmd.out_kind   = kind_ff;
      cmd.out_status = status_ff;
      req_ready      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready       = 1'b1;
            cmd.capture     = req_valid;
            cmd.table_write = req_valid && (req_cmd == CMD_WRITE);
         end
         S_CHECK:     cmd.div_start = (stat.early_status == ST_OK);
         S_DIVIDE:    ;
         S_MUL_GROUP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GROUP;
         end
         S_RANGE:     ;
         S_MUL_LOCAL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LOCAL;
         end
         S_FINISH:    cmd.load_out = stat.out_free;
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         kind_ff   <= OUT_ZERO;
         status_ff <= ST_OK;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_cmd == CMD_WRITE) begin
                     kind_ff   <= OUT_ZERO;
                     status_ff <= ST_OK;
                     state_ff  <= S_FINISH;
                  end else begin
                     state_ff <= S_CHECK;
                  end
               end
            end
            S_CHECK: begin
               if (stat.early_status != ST_OK) begin
                  kind_ff   <= OUT_ZERO;
                  status_ff <= stat.early_status;
                  state_ff  <= S_FINISH;
               end else begin
                  state_ff <= S_DIVIDE;
               end
            end
            S_DIVIDE: begin
               if (!stat.div_busy) begin
                  state_ff <= S_MUL_GROUP;
               end
            end
            S_MUL_GROUP: state_ff <= S_RANGE;
            S_RANGE: begin
               if (stat.group_bad) begin
                  kind_ff   <= OUT_RANGE;
                  status_ff <= ST_GROUP_RANGE;
                  state_ff  <= S_FINISH;
               end else begin
                  state_ff <= S_MUL_LOCAL;
               end
            end
            S_MUL_LOCAL: begin
               kind_ff   <= OUT_FULL;
               status_ff <= ST_OK;
               state_ff  <= S_FINISH;
            end
            S_FINISH: begin
               if (stat.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/inode_byte_locator.sv -----
// inode_byte_locator top level; depends on ibl_pkg, ibl_ctrl, ibl_datapath.
// A table write goes straight to the result; geometry/number errors stop after
// the check, a group out of range after the range test, and a full lookup also
// runs the local multiply; checked lookups wait on the 32-step radix-2 divider.
// One item at a time, the next taken in the cycle after the result is loaded.
// Reset (synchronous, active high) clears control and configuration only.
`default_nettype none

module inode_byte_locator (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration write port
   input  wire logic        csr_write_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_write_data,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_cmd,
   input  wire logic [7:0]  req_group_slot,
   input  wire logic [31:0] req_table_start_block,
   input  wire logic [31:0] req_inode_number,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [48:0]      rsp_byte_offset,
   output logic [31:0]      rsp_group_number,
   output logic [31:0]      rsp_local_index
);
   import ibl_pkg::*;

   // Flow of a lookup:
   //  - capture the inode number, then check geometry and number range
   //  - divide (inode - 1) by inodes per group: quotient is the group,
   //    remainder the local index
   //  - multiply group by blocks per group and compare with the block
   //    count: this is the rounded-up group count test without a second
   //    divide; read the group's table start block in the same cycle
   //  - multiply local index by inode size, then shift and add for the
   //    byte offset as the result register is loaded
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   ibl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   ibl_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_group_slot        (req_group_slot),
      .req_table_start_block (req_table_start_block),
      .req_inode_number      (req_inode_number),
      .cmd                   (dp_cmd),
      .stat                  (dp_stat),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_byte_offset       (rsp_byte_offset),
      .rsp_group_number      (rsp_group_number),
      .rsp_local_index       (rsp_local_index)
   );

endmodule

`default_nettype wire

// ----- tb/ibl_location_checker.sv -----
// Location checker for the inode byte locator: watches the csr, request and
// response ports, predicts each result and compares it field by field.
// Depends on ibl_pkg for the status and register codes.
`default_nettype none

module ibl_location_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_write_data,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        req_cmd,
   input  wire logic [7:0]  req_group_slot,
   input  wire logic [31:0] req_table_start_block,
   input  wire logic [31:0] req_inode_number,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [2:0]  rsp_status,
   input  wire logic [48:0] rsp_byte_offset,
   input  wire logic [31:0] rsp_group_number,
   input  wire logic [31:0] rsp_local_index,
   output int unsigned      mismatches,
   output int unsigned      outstanding
);
   import ibl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type  status;
      logic [48:0] byte_offset;
      logic [31:0] group_number;
      logic [31:0] index_in_group;
   } inode_location_type;

   // shadow of the configuration registers
   logic [31:0] n_inodes;
   logic [31:0] per_group;
   logic [31:0] n_blocks;
   logic [31:0] blocks_per_grp;
   logic [3:0]  size_log;
   logic        dyn_rev;
   logic [15:0] rec_size;

   logic [31:0]        table_start [MAX_GROUPS];
   inode_location_type awaited_locations [$];
   inode_location_type want;
   int unsigned        n_fail;

   function automatic inode_location_type locate_inode(logic [31:0] ino);
      inode_location_type r;
      logic [31:0]     isize;
      logic [31:0]     idx;
      logic [31:0]     grp;
      logic [31:0]     loc;
      logic [63:0]     groups;
      logic [63:0]     offset;
      r = '{ST_OK, '0, '0, '0};
      isize = dyn_rev ? {16'b0, rec_size} : 32'(FIXED_INODE_SIZE);
      if (size_log > MAX_SIZE_LOG || blocks_per_grp == 0 || isize < MIN_INODE_SIZE)
         r.status = ST_GEOMETRY;
      else if (ino == 0)
         r.status = ST_INO_ZERO;
      else if (ino > n_inodes)
         r.status = ST_PAST_COUNT;
      else if (per_group == 0)
         r.status = ST_ZERO_PER_GROUP;
      else begin
         idx = ino - 32'd1;
         grp = idx / per_group;
         loc = idx % per_group;
         groups = (64'(n_blocks) + 64'(blocks_per_grp) - 64'd1) / 64'(blocks_per_grp);
         r.group_number   = grp;
         r.index_in_group = loc;
         if (64'(grp) >= groups || grp >= MAX_GROUPS)
            r.status = ST_GROUP_RANGE;
         else begin
            offset = (64'(table_start[grp[7:0]]) << BASE_BLOCK_LOG) << size_log;
            offset = offset + 64'(loc) * 64'(isize);
            r.byte_offset = offset[48:0];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         n_inodes       = '0;
         per_group      = '0;
         n_blocks       = '0;
         blocks_per_grp = '0;
         size_log       = '0;
         dyn_rev        = 1'b0;
         rec_size       = 16'd128;
         awaited_locations.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_INODES_TOTAL:      n_inodes       = csr_write_data;
               CSR_INODES_PER_GROUP:  per_group      = csr_write_data;
               CSR_BLOCKS_TOTAL:      n_blocks       = csr_write_data;
               CSR_BLOCKS_PER_GROUP:  blocks_per_grp = csr_write_data;
               CSR_BLOCK_SIZE_LOG:    size_log       = csr_write_data[3:0];
               CSR_DYNAMIC_REVISION:  dyn_rev        = csr_write_data[0];
               CSR_STORED_INODE_SIZE: rec_size       = csr_write_data[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_locations.size() == 0) begin
               if (n_fail < 10)
                  $display({"%0t: result with nothing awaited: ",
                            "status %0d offset %h group %h index %h"},
                           $realtime, rsp_status, rsp_byte_offset, rsp_group_number,
                           rsp_local_index);
               n_fail++;
            end else begin
               want = awaited_locations.pop_front();
               if (rsp_status !== want.status || rsp_byte_offset !== want.byte_offset ||
                   rsp_group_number !== want.group_number ||
                   rsp_local_index !== want.index_in_group) begin
                  if (n_fail < 10) begin
                     $display("%0t: mismatch, expected status %0d offset %h group %h index %h",
                              $realtime, want.status, want.byte_offset, want.group_number,
                              want.index_in_group);
                     $display("%0t:           got      status %0d offset %h group %h index %h",
                              $realtime, rsp_status, rsp_byte_offset, rsp_group_number,
                              rsp_local_index);
                  end
                  n_fail++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_WRITE) begin
               table_start[req_group_slot] = req_table_start_block;
               awaited_locations.push_back('{ST_OK, '0, '0, '0});
            end else
               awaited_locations.push_back(locate_inode(req_inode_number));
         end
      end
      mismatches  <= n_fail;
      outstanding <= awaited_locations.size();
   end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Top of the inode byte locator testbench: clock, reset, csr setup and
// request/response traffic, verdict. Depends on ibl_pkg, inode_byte_locator
// and ibl_location_checker.
`default_nettype none

module tb_top;
   import ibl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned SETTLE_CYCLES = 45;     // slowest lookup plus margin
   localparam int unsigned PHASES        = 8;
   localparam int unsigned PHASE_ITEMS   = 100;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_write_data;
   logic        req_valid;
   logic        req_ready;
   logic        req_cmd;
   logic [7:0]  req_group_slot;
   logic [31:0] req_table_start_block;
   logic [31:0] req_inode_number;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [48:0] rsp_byte_offset;
   logic [31:0] rsp_group_number;
   logic [31:0] rsp_local_index;
   int unsigned mismatches;
   int unsigned outstanding;

   // stimulus-side copy of the registers, used only to shape legal lookups
   logic [31:0] cfg_total;
   logic [31:0] cfg_ipg;
   logic [31:0] cfg_bt;
   logic [31:0] cfg_bpg;
   logic [3:0]  cfg_log;
   logic        cfg_dyn;
   logic [15:0] cfg_size;
   bit          slot_written [MAX_GROUPS];

   // idling controls: quiet turns off every gap and stall
   bit          quiet;
   int unsigned idle_span;
   int unsigned cycle_count;

   inode_byte_locator dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_group_slot        (req_group_slot),
      .req_table_start_block (req_table_start_block),
      .req_inode_number      (req_inode_number),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_byte_offset       (rsp_byte_offset),
      .rsp_group_number      (rsp_group_number),
      .rsp_local_index       (rsp_local_index)
   );

   ibl_location_checker u_location_check (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_group_slot        (req_group_slot),
      .req_table_start_block (req_table_start_block),
      .req_inode_number      (req_inode_number),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_byte_offset       (rsp_byte_offset),
      .rsp_group_number      (rsp_group_number),
      .rsp_local_index       (rsp_local_index),
      .mismatches            (mismatches),
      .outstanding           (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: a hung handshake must not run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // Response back-pressure: drop ready for bursts of random length.
   initial begin
      int unsigned hold;
      hold = 0;
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold != 0)
            hold--;
         else if (!quiet && $urandom_range(0, idle_span) == 0) begin
            hold = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= 1'b1;
      end
   end

   // Present one item and hold it until the block takes it. An optional gap
   // of random length with valid low goes in front.
   task automatic send(logic cmd, logic [7:0] slot, logic [31:0] start, logic [31:0] ino);
      if (!quiet && $urandom_range(0, idle_span) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      @(negedge clock);
      req_valid             <= 1'b1;
      req_cmd               <= cmd;
      req_group_slot        <= slot;
      req_table_start_block <= start;
      req_inode_number      <= ino;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic put_table(logic [7:0] slot, logic [31:0] start);
      send(CMD_WRITE, slot, start, $urandom);
      slot_written[slot] = 1'b1;
   endtask

   // True when a lookup of this inode gets as far as reading the group map.
   function automatic bit reads_group_map(logic [31:0] ino);
      logic [31:0] isize;
      logic [31:0] grp;
      logic [63:0] groups;
      isize = cfg_dyn ? {16'b0, cfg_size} : 32'(FIXED_INODE_SIZE);
      if (cfg_log > MAX_SIZE_LOG || cfg_bpg == 0 || isize < MIN_INODE_SIZE || ino == 0 ||
          ino > cfg_total || cfg_ipg == 0)
         return 1'b0;
      grp = (ino - 32'd1) / cfg_ipg;
      groups = (64'(cfg_bt) + 64'(cfg_bpg) - 64'd1) / 64'(cfg_bpg);
      return 64'(grp) < groups && grp < MAX_GROUPS;
   endfunction

   // Never look into a map entry that has not been written: fill it first.
   task automatic locate(logic [31:0] ino);
      logic [31:0] grp;
      if (reads_group_map(ino)) begin
         grp = (ino - 32'd1) / cfg_ipg;
         if (!slot_written[grp[7:0]])
            put_table(grp[7:0], $urandom);
      end
      send(CMD_LOCATE, 8'($urandom), $urandom, ino);
   endtask

   // Drop valid and wait until the block has nothing left in flight.
   task automatic settle;
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_csr(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_INODES_TOTAL:      cfg_total = value;
         CSR_INODES_PER_GROUP:  cfg_ipg   = value;
         CSR_BLOCKS_TOTAL:      cfg_bt    = value;
         CSR_BLOCKS_PER_GROUP:  cfg_bpg   = value;
         CSR_BLOCK_SIZE_LOG:    cfg_log   = value[3:0];
         CSR_DYNAMIC_REVISION:  cfg_dyn   = value[0];
         CSR_STORED_INODE_SIZE: cfg_size  = value[15:0];
         default: ;
      endcase
   endtask

   task automatic close_csr;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Pick a geometry for one random phase. Most phases give a sane layout so
   // lookups land in real groups; a wild phase throws full-width values in.
   task automatic random_setup(bit wild);
      logic [63:0] groups;
      logic [63:0] blocks;
      logic [63:0] inodes;
      logic [31:0] bpg;
      logic [31:0] ipg;
      if (wild) begin
         set_csr(CSR_INODES_TOTAL, $urandom);
         set_csr(CSR_INODES_PER_GROUP, $urandom);
         set_csr(CSR_BLOCKS_TOTAL, $urandom);
         set_csr(CSR_BLOCKS_PER_GROUP, $urandom);
         set_csr(CSR_BLOCK_SIZE_LOG, $urandom_range(0, 15));
         set_csr(CSR_DYNAMIC_REVISION, $urandom_range(0, 1));
         set_csr(CSR_STORED_INODE_SIZE, $urandom);
      end else begin
         groups = 64'($urandom_range(1, 300));
         bpg = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(1, 32'h0010_0000);
         blocks = (groups - 64'd1) * 64'(bpg) + 64'($urandom_range(1, bpg));
         case ($urandom_range(0, 2))
            0:       ipg = $urandom_range(1, 8);
            1:       ipg = $urandom_range(1, 4096);
            default: ipg = $urandom;
         endcase
         if (groups > MAX_GROUPS)
            groups = 64'(MAX_GROUPS);
         inodes = groups * 64'(ipg) + 64'($urandom_range(0, 500));
         set_csr(CSR_INODES_TOTAL, (inodes > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : inodes[31:0]);
         set_csr(CSR_INODES_PER_GROUP, ipg);
         set_csr(CSR_BLOCKS_TOTAL, (blocks > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : blocks[31:0]);
         set_csr(CSR_BLOCKS_PER_GROUP, bpg);
         set_csr(CSR_BLOCK_SIZE_LOG,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(7, 15) : $urandom_range(0, 6));
         set_csr(CSR_DYNAMIC_REVISION, $urandom_range(0, 1));
         set_csr(CSR_STORED_INODE_SIZE,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                             : $urandom_range(128, 16'hFFFF));
      end
      close_csr();
   endtask

   // One random item: mostly lookups aimed at real groups, some map writes,
   // and some noise around the error cases.
   task automatic random_item;
      int unsigned pick;
      logic [63:0] groups;
      logic [63:0] ino_wide;
      logic [31:0] ino;
      pick = $urandom_range(0, 99);
      if (pick < 15)
         put_table(8'($urandom_range(0, 255)), $urandom);
      else if (pick < 82) begin
         groups = (cfg_bpg == 0) ? 64'd0
                                 : (64'(cfg_bt) + 64'(cfg_bpg) - 64'd1) / 64'(cfg_bpg);
         if (groups > MAX_GROUPS)
            groups = 64'(MAX_GROUPS);
         if (groups == 0 || cfg_ipg == 0)
            ino = $urandom_range(1, 1000);
         else begin
            ino_wide = 64'($urandom_range(0, 32'(groups - 64'd1))) * 64'(cfg_ipg) + 64'd1 +
                       64'(($urandom_range(0, 3) == 0) ? cfg_ipg - 32'd1
                                                       : $urandom_range(0, cfg_ipg - 1));
            if (ino_wide > 64'(cfg_total))
               ino = (cfg_total == 0) ? 32'd1 : $urandom_range(1, cfg_total);
            else
               ino = ino_wide[31:0];
         end
         locate(ino);
      end else begin
         case ($urandom_range(0, 3))
            0:       locate('0);
            1:       locate(cfg_total + 32'd1);
            2:       locate($urandom);
            default: locate(cfg_ipg * $urandom_range(1, 300) + 32'd1);
         endcase
      end
   endtask

   initial begin
      reset                 = 1'b1;
      csr_write_en          = 1'b0;
      csr_index             = '0;
      csr_write_data        = '0;
      req_valid             = 1'b0;
      req_cmd               = CMD_WRITE;
      req_group_slot        = '0;
      req_table_start_block = '0;
      req_inode_number      = '0;
      cycle_count           = 0;
      quiet                 = 1'b0;
      idle_span             = 3;
      cfg_total             = '0;
      cfg_ipg               = '0;
      cfg_bt                = '0;
      cfg_bpg               = '0;
      cfg_log               = '0;
      cfg_dyn               = 1'b0;
      cfg_size              = 16'd128;
      foreach (slot_written[i])
         slot_written[i] = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Straight out of reset blocks_per_group is zero: geometry error.
      put_table(8'd0, 32'hFFFF_FFFF);
      put_table(8'd255, 32'h0000_0000);
      put_table(8'd1, 32'h0000_0001);
      locate(32'd1);

      // Ten groups of 100 inodes; block-size log just past and far past the limit.
      settle();
      set_csr(CSR_INODES_TOTAL, 32'hFFFF_FFFF);
      set_csr(CSR_INODES_PER_GROUP, 32'd100);
      set_csr(CSR_BLOCKS_TOTAL, 32'd1000);
      set_csr(CSR_BLOCKS_PER_GROUP, 32'd100);
      set_csr(CSR_BLOCK_SIZE_LOG, 32'd7);
      set_csr(CSR_DYNAMIC_REVISION, 32'd0);
      set_csr(CSR_STORED_INODE_SIZE, 32'h0000_FFFF);
      close_csr();
      locate(32'd1);
      settle();
      set_csr(CSR_BLOCK_SIZE_LOG, 32'd15);
      close_csr();
      locate(32'd1);

      // Largest legal block size: inode zero, group edges, past the group count.
      settle();
      set_csr(CSR_BLOCK_SIZE_LOG, 32'd6);
      close_csr();
      locate(32'd0);
      locate(32'd1);
      locate(32'd100);
      locate(32'd101);
      locate(32'd1000);
      locate(32'd1001);
      locate(32'hFFFF_FFFF);

      // Dynamic revision: inode size just under the minimum, then the largest.
      settle();
      set_csr(CSR_DYNAMIC_REVISION, 32'd1);
      set_csr(CSR_STORED_INODE_SIZE, 32'd127);
      close_csr();
      locate(32'd5);
      settle();
      set_csr(CSR_STORED_INODE_SIZE, 32'h0000_FFFF);
      close_csr();
      locate(32'd100);
      locate(32'd200);

      // No inodes at all, then zero inodes per group.
      settle();
      set_csr(CSR_INODES_TOTAL, 32'd0);
      close_csr();
      locate(32'd1);
      settle();
      set_csr(CSR_INODES_TOTAL, 32'hFFFF_FFFF);
      set_csr(CSR_INODES_PER_GROUP, 32'd0);
      close_csr();
      locate(32'd7);

      // One inode per group, huge group count: the map depth limits instead.
      settle();
      set_csr(CSR_INODES_PER_GROUP, 32'd1);
      set_csr(CSR_BLOCKS_TOTAL, 32'hFFFF_FFFF);
      set_csr(CSR_BLOCKS_PER_GROUP, 32'd1);
      set_csr(CSR_BLOCK_SIZE_LOG, 32'd0);
      set_csr(CSR_STORED_INODE_SIZE, 32'd128);
      close_csr();
      locate(32'd256);
      locate(32'd257);

      // No blocks: every group is out of range.
      settle();
      set_csr(CSR_BLOCKS_TOTAL, 32'd0);
      close_csr();
      locate(32'd1);

      // All-ones counts: one group holding every inode, last local index.
      settle();
      set_csr(CSR_BLOCKS_TOTAL, 32'hFFFF_FFFF);
      set_csr(CSR_BLOCKS_PER_GROUP, 32'hFFFF_FFFF);
      set_csr(CSR_INODES_PER_GROUP, 32'hFFFF_FFFF);
      close_csr();
      locate(32'hFFFF_FFFF);

      // Random phases, each with its own geometry and idling mix; the last
      // phase runs flat out on both sides.
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         settle();
         random_setup(phase == 3 || phase == 6);
         quiet     = (phase % 4 == 1) || (phase == PHASES - 1);
         idle_span = $urandom_range(1, 6);
         repeat (PHASE_ITEMS) random_item();
      end

      settle();
      if (mismatches == 0 && outstanding == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

`default_nettype wire
